>>> rtl/zff_pkg.sv
// Shared types, constants and binary32 arithmetic helpers for the ZMP unit.
package zff_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int NUM_REGS = 6;

  localparam logic [2:0] REG_RF_POLY = 3'd0;
  localparam logic [2:0] REG_LF_POLY = 3'd1;
  localparam logic [2:0] REG_RB_POLY = 3'd2;
  localparam logic [2:0] REG_LB_POLY = 3'd3;
  localparam logic [2:0] REG_LOAD_POLY = 3'd4;
  localparam logic [2:0] REG_GEOMETRY = 3'd5;

  // 0.00981 as binary32
  localparam logic [31:0] K_GRAV = 32'h3C20BA1F;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
  localparam logic [31:0] QUIET_BIT = 32'h00400000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] force_right_front;
    logic [SAMPLE_BITS-1:0] force_left_front;
    logic [SAMPLE_BITS-1:0] force_right_back;
    logic [SAMPLE_BITS-1:0] force_left_back;
  } zff_in_t;

  typedef struct packed {
    logic [31:0] zmp_x;
    logic [31:0] zmp_y;
    logic [31:0] reaction_force;
    logic        zero_reaction;
  } zff_out_t;

  // multiplier first half: specials resolved, raw significand product
  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [11:0] exp;
    logic [47:0]        prod;
  } zff_mul_t;

  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // m[26] is the leading one, m[2:0] guard bits with sticky folded into m[0]
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] be,
                                             logic [26:0] m);
    logic [26:0] m2;
    logic [11:0] sh;
    logic [53:0] ext;
    logic [7:0]  eb;
    logic        rnd;
    logic [31:0] tmp;
    if (be < 12'sd1) begin
      sh = 12'(12'sd1 - be);
      if (sh > 12'd27) sh = 12'd27;
      ext = {m, 27'd0} >> sh;
      m2 = ext[53:27] | {26'd0, |ext[26:0]};
      eb = 8'd0;
    end else begin
      m2 = m;
      eb = be[7:0];
    end
    rnd = m2[2] & (m2[3] | m2[1] | m2[0]);
    tmp = {1'b0, eb, m2[25:3]} + {31'd0, rnd};
    if (be > 12'sd254) return {s, 8'hFF, 23'd0};
    return {s, tmp[30:0]};
  endfunction

  function automatic logic [31:0] h2f(logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [22:0] fr;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    fr = {m, 13'd0} << (4'd10 - p);
    if (e == 5'd31) return {s, 8'hFF, m, 13'd0};
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, {4'd0, p} + 8'd103, fr};
    end
    return {s, {3'd0, e} + 8'd112, m, 13'd0};
  endfunction

  function automatic logic [31:0] i2f(logic [15:0] v);
    logic [5:0]  lz;
    logic [15:0] vn;
    lz = lzc48({v, 32'd0});
    vn = v << lz;
    if (v == 16'd0) return 32'd0;
    return {1'b0, 8'd142 - {2'd0, lz}, vn[14:0], 8'd0};
  endfunction

  function automatic zff_mul_t mul_pre(logic [31:0] a, logic [31:0] b);
    zff_mul_t r;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    r.spec = 1'b1;
    r.sign = a[31] ^ b[31];
    r.exp  = $signed({4'd0, ea}) + $signed({4'd0, eb});
    r.prod = {24'd0, ma} * {24'd0, mb};
    r.sval = {r.sign, 31'd0};
    if (is_nan(a)) r.sval = a | QUIET_BIT;
    else if (is_nan(b)) r.sval = b | QUIET_BIT;
    else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) r.sval = DEFAULT_NAN;
    else if (is_inf(a) || is_inf(b)) r.sval = {r.sign, 8'hFF, 23'd0};
    else if (is_zero(a) || is_zero(b)) r.sval = {r.sign, 31'd0};
    else r.spec = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] mul_post(zff_mul_t r);
    logic [5:0]         lz;
    logic [47:0]        pn;
    logic signed [11:0] be;
    lz = lzc48(r.prod);
    pn = r.prod << lz;
    be = r.exp - 12'sd126 - $signed({6'd0, lz});
    if (r.spec) return r.sval;
    return round_pack(r.sign, be, {pn[47:22], |pn[21:0]});
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0]        x, y;
    logic [7:0]         ex, ey, d;
    logic [26:0]        mx, my, mys;
    logic [53:0]        ext;
    logic [27:0]        sum, sn;
    logic [5:0]         lz;
    logic signed [11:0] be;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0], 3'd0};
    my = {y[30:23] != 8'd0, y[22:0], 3'd0};
    d = ex - ey;
    if (d > 8'd27) d = 8'd27;
    ext = {my, 27'd0} >> d;
    mys = ext[53:27] | {26'd0, |ext[26:0]};
    if (x[31] == y[31]) sum = {1'b0, mx} + {1'b0, mys};
    else sum = {1'b0, mx} - {1'b0, mys};
    lz = lzc48({sum, 20'd0});
    sn = sum << lz;
    be = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return DEFAULT_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (sum == 28'd0) return 32'd0;
    return round_pack(x[31], be, {sn[27:2], |sn[1:0]});
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    return fadd(a, is_nan(b) ? b : {~b[31], b[30:0]});
  endfunction

endpackage

>>> rtl/zff_poly.sv
// Pipelined load polynomial c3*v^3 + c2*v^2 + c1*v.
module zff_poly (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] v,
  input  logic [31:0] c3,
  input  logic [31:0] c2,
  input  logic [31:0] c1,
  output logic [31:0] s
);
  import zff_pkg::*;

  zff_mul_t    p1_m3, p1_m2, p1_m1, p3_m3, p3_m2, p5_m3;
  logic [31:0] p1_v, p2_t3, p2_t2, p2_t1, p2_v, p3_t1, p3_v;
  logic [31:0] p4_t3, p4_t2, p4_t1, p4_v, p5_t2, p5_t1;
  logic [31:0] p6_t3, p6_t2, p6_t1, p7_s, p7_t1;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_m3 <= mul_pre(c3, v);
      p1_m2 <= mul_pre(c2, v);
      p1_m1 <= mul_pre(c1, v);
      p1_v  <= v;
      p2_t3 <= mul_post(p1_m3);
      p2_t2 <= mul_post(p1_m2);
      p2_t1 <= mul_post(p1_m1);
      p2_v  <= p1_v;
      p3_m3 <= mul_pre(p2_t3, p2_v);
      p3_m2 <= mul_pre(p2_t2, p2_v);
      p3_t1 <= p2_t1;
      p3_v  <= p2_v;
      p4_t3 <= mul_post(p3_m3);
      p4_t2 <= mul_post(p3_m2);
      p4_t1 <= p3_t1;
      p4_v  <= p3_v;
      p5_m3 <= mul_pre(p4_t3, p4_v);
      p5_t2 <= p4_t2;
      p5_t1 <= p4_t1;
      p6_t3 <= mul_post(p5_m3);
      p6_t2 <= p5_t2;
      p6_t1 <= p5_t1;
      p7_s  <= fadd(p6_t3, p6_t2);
      p7_t1 <= p6_t1;
      s     <= fadd(p7_s, p7_t1);
    end
  end

endmodule

>>> rtl/zff_div.sv
// Pipelined binary32 divider, two quotient bits per stage.
module zff_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import zff_pkg::*;

  localparam int STEPS = 13;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [11:0] be;
    logic [24:0]        rem;
    logic [23:0]        dv;
    logic [25:0]        q;
  } div_t;

  function automatic div_t div_iter(div_t d);
    div_t r;
    r = d;
    for (int i = 0; i < 2; i++) begin
      if (r.rem >= {1'b0, r.dv}) begin
        r.rem = r.rem - {1'b0, r.dv};
        r.q = {r.q[24:0], 1'b1};
      end else begin
        r.q = {r.q[24:0], 1'b0};
      end
      r.rem = {r.rem[23:0], 1'b0};
    end
    return r;
  endfunction

  div_t               st [0:STEPS];
  div_t               d0;
  logic [23:0]        ma, mb, man, mbn;
  logic [7:0]         ea, eb;
  logic [5:0]         la, lb;
  logic signed [11:0] ean, ebn;

  always_comb begin
    ma  = {num[30:23] != 8'd0, num[22:0]};
    mb  = {den[30:23] != 8'd0, den[22:0]};
    ea  = (num[30:23] == 8'd0) ? 8'd1 : num[30:23];
    eb  = (den[30:23] == 8'd0) ? 8'd1 : den[30:23];
    la  = lzc48({ma, 24'd0});
    lb  = lzc48({mb, 24'd0});
    man = ma << la;
    mbn = mb << lb;
    ean = $signed({4'd0, ea}) - $signed({6'd0, la});
    ebn = $signed({4'd0, eb}) - $signed({6'd0, lb});
    d0.sign = num[31] ^ den[31];
    d0.dv   = mbn;
    d0.q    = 26'd0;
    if (man < mbn) begin
      d0.rem = {man, 1'b0};
      d0.be  = ean - ebn + 12'sd126;
    end else begin
      d0.rem = {1'b0, man};
      d0.be  = ean - ebn + 12'sd127;
    end
    d0.spec = 1'b1;
    d0.sval = {d0.sign, 31'd0};
    if (is_nan(num)) d0.sval = num | QUIET_BIT;
    else if (is_nan(den)) d0.sval = den | QUIET_BIT;
    else if ((is_zero(num) && is_zero(den)) || (is_inf(num) && is_inf(den)))
      d0.sval = DEFAULT_NAN;
    else if (is_inf(num) || is_zero(den)) d0.sval = {d0.sign, 8'hFF, 23'd0};
    else if (is_inf(den) || is_zero(num)) d0.sval = {d0.sign, 31'd0};
    else d0.spec = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= d0;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= div_iter(st[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= st[STEPS].spec ? st[STEPS].sval :
             round_pack(st[STEPS].sign, st[STEPS].be,
                        {st[STEPS].q, st[STEPS].rem != 25'd0});
    end
  end

endmodule

>>> rtl/zmp_from_foot_force_sensors_unit.sv
// Top level: zero moment point from four foot force sensors, binary32 pipeline.
//
//   channel  | direction | handshake                 | word
//   sample   | in        | sample_valid/sample_stall | zff_in_t, four raw counts
//   zmp      | out       | zmp_valid/zmp_stall       | zff_out_t, x, y, force, flag
//   config   | in        | APB psel/penable/pwrite   | 64-bit regs at 8*index
//
// One word per cycle while the output is not stalled.
// Latency is set by the float op chain and the divider.
// A stalled output word freezes the whole pipeline; sample_stall follows it.
// rst is synchronous and clears valid bits and configuration registers.
module zmp_from_foot_force_sensors_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  zff_pkg::zff_in_t    sample,
  output logic                zmp_valid,
  input  logic                zmp_stall,
  output zff_pkg::zff_out_t   zmp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import zff_pkg::*;

  localparam int DEPTH = 42;
  localparam int DIV_LAT = 15;

  logic [47:0] cal [0:3];
  logic [47:0] load_poly;
  logic [63:0] geometry;

  logic [31:0] ca [0:3];
  logic [31:0] cb [0:3];
  logic [31:0] cc [0:3];
  logic [31:0] c3, c2, c1, lx, ly, mx, my;
  logic [15:0] fin [0:3];

  logic        en;
  logic [DEPTH:1] vld;

  logic [31:0] s1_f [0:3];
  zff_mul_t    s2_ma [0:3];
  zff_mul_t    s2_mb [0:3];
  logic [31:0] s2_f [0:3];
  logic [31:0] s3_t1 [0:3];
  logic [31:0] s3_t2 [0:3];
  logic [31:0] s3_f [0:3];
  zff_mul_t    s4_ma [0:3];
  logic [31:0] s4_t2 [0:3];
  logic [31:0] s5_t1 [0:3];
  logic [31:0] s5_t2 [0:3];
  logic [31:0] s6_p [0:3];
  logic [31:0] s7_p [0:3];
  logic [31:0] s8_p [0:3];
  logic [31:0] s9_p [0:3];
  logic [31:0] s10_p [0:3];
  logic [31:0] s8_r, s9_r, s10_r, s11_r;
  logic [31:0] q15 [0:3];
  logic [31:0] qd [0:5][0:3];
  logic [31:0] l19;
  zff_mul_t    s20_m;
  logic [31:0] s21_rf, s22_rf, s23_rf, s24_rf, s25_rf, s26_rf;
  logic [31:0] s22_tx, s22_ty;
  zff_mul_t    s23_mx, s23_my, s25_mx, s25_my;
  logic [31:0] s24_tx, s24_ty, s26_tx, s26_ty;
  logic [31:0] rfd [0:DIV_LAT-1];
  logic [31:0] dx, dy;
  logic        zr;

  assign pready = 1'b1;
  assign en = !(zmp_valid && zmp_stall);
  assign sample_stall = !en;
  assign zmp_valid = vld[DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) cal[i] <= 48'd0;
      load_poly <= 48'd0;
      geometry <= 64'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_RF_POLY:   cal[0] <= pwdata[47:0];
        REG_LF_POLY:   cal[1] <= pwdata[47:0];
        REG_RB_POLY:   cal[2] <= pwdata[47:0];
        REG_LB_POLY:   cal[3] <= pwdata[47:0];
        REG_LOAD_POLY: load_poly <= pwdata[47:0];
        REG_GEOMETRY:  geometry <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_RF_POLY:   prdata = {16'd0, cal[0]};
      REG_LF_POLY:   prdata = {16'd0, cal[1]};
      REG_RB_POLY:   prdata = {16'd0, cal[2]};
      REG_LB_POLY:   prdata = {16'd0, cal[3]};
      REG_LOAD_POLY: prdata = {16'd0, load_poly};
      REG_GEOMETRY:  prdata = geometry;
      default:       prdata = 64'd0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ca[i] = h2f(cal[i][47:32]);
      cb[i] = h2f(cal[i][31:16]);
      cc[i] = h2f(cal[i][15:0]);
    end
    c3 = h2f(load_poly[47:32]);
    c2 = h2f(load_poly[31:16]);
    c1 = h2f(load_poly[15:0]);
    lx = h2f(geometry[63:48]);
    ly = h2f(geometry[47:32]);
    mx = h2f(geometry[31:16]);
    my = h2f(geometry[15:0]);
    fin[0] = 16'(sample.force_right_front);
    fin[1] = 16'(sample.force_left_front);
    fin[2] = 16'(sample.force_right_back);
    fin[3] = 16'(sample.force_left_back);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-1:1], sample_valid};
    end
  end

  // calibration and running sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_f[i]  <= i2f(fin[i]);
        s2_ma[i] <= mul_pre(ca[i], s1_f[i]);
        s2_mb[i] <= mul_pre(cb[i], s1_f[i]);
        s2_f[i]  <= s1_f[i];
        s3_t1[i] <= mul_post(s2_ma[i]);
        s3_t2[i] <= mul_post(s2_mb[i]);
        s3_f[i]  <= s2_f[i];
        s4_ma[i] <= mul_pre(s3_t1[i], s3_f[i]);
        s4_t2[i] <= s3_t2[i];
        s5_t1[i] <= mul_post(s4_ma[i]);
        s5_t2[i] <= s4_t2[i];
        s6_p[i]  <= fadd(s5_t1[i], s5_t2[i]);
        s7_p[i]  <= fadd(s6_p[i], cc[i]);
        s8_p[i]  <= s7_p[i];
        s9_p[i]  <= s8_p[i];
        s10_p[i] <= s9_p[i];
      end
      s8_r  <= fadd(32'd0, s7_p[0]);
      s9_r  <= fadd(s8_r, s8_p[1]);
      s10_r <= fadd(s9_r, s9_p[2]);
      s11_r <= fadd(s10_r, s10_p[3]);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    zff_poly u_poly (
      .clk (clk),
      .en  (en),
      .v   (s7_p[i]),
      .c3  (c3),
      .c2  (c2),
      .c1  (c1),
      .s   (q15[i])
    );
  end

  zff_poly u_poly_sum (
    .clk (clk),
    .en  (en),
    .v   (s11_r),
    .c3  (c3),
    .c2  (c2),
    .c1  (c1),
    .s   (l19)
  );

  // moments
  always_ff @(posedge clk) begin
    if (en) begin
      qd[0] <= q15;
      for (int k = 1; k < 6; k++) qd[k] <= qd[k-1];
      s20_m  <= mul_pre(l19, K_GRAV);
      s21_rf <= mul_post(s20_m);
      s22_tx <= fadd(qd[5][0], qd[5][2]);
      s22_ty <= fadd(qd[5][0], qd[5][1]);
      s22_rf <= s21_rf;
      s23_mx <= mul_pre(s22_tx, lx);
      s23_my <= mul_pre(s22_ty, ly);
      s23_rf <= s22_rf;
      s24_tx <= mul_post(s23_mx);
      s24_ty <= mul_post(s23_my);
      s24_rf <= s23_rf;
      s25_mx <= mul_pre(s24_tx, K_GRAV);
      s25_my <= mul_pre(s24_ty, K_GRAV);
      s25_rf <= s24_rf;
      s26_tx <= mul_post(s25_mx);
      s26_ty <= mul_post(s25_my);
      s26_rf <= s25_rf;
      rfd[0] <= s26_rf;
      for (int k = 1; k < DIV_LAT; k++) rfd[k] <= rfd[k-1];
    end
  end

  zff_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (s26_tx),
    .den (s26_rf),
    .quo (dx)
  );

  zff_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (s26_ty),
    .den (s26_rf),
    .quo (dy)
  );

  assign zr = rfd[DIV_LAT-1][30:0] == 31'd0;

  always_ff @(posedge clk) begin
    if (en) begin
      zmp.zmp_x          <= zr ? 32'd0 : fsub(dx, mx);
      zmp.zmp_y          <= zr ? 32'd0 : fsub(dy, my);
      zmp.reaction_force <= rfd[DIV_LAT-1];
      zmp.zero_reaction  <= zr;
    end
  end

`ifndef SYNTHESIS
  a_zero_forces_xy: assert property (@(posedge clk) disable iff (rst)
    zmp_valid && zmp.zero_reaction |-> zmp.zmp_x == 32'd0 && zmp.zmp_y == 32'd0)
    else $error("zero reaction with nonzero zmp");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    zmp_valid |-> zmp.zero_reaction == (zmp.reaction_force[30:0] == 31'd0))
    else $error("zero flag does not match reaction force");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !zmp_valid)
    else $error("valid word right after reset");

  a_stall_ties: assert property (@(posedge clk) disable iff (rst)
    sample_stall && !rst |=> $stable(vld))
    else $error("pipeline moved while stalled");
`endif

endmodule

>>> tb/zmp_from_foot_force_sensors_unit_tb.sv
// Testbench for the ZMP unit: binary32 predictor, scoreboard and random stimulus.
module zmp_from_foot_force_sensors_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import zff_pkg::*;

  localparam logic [31:0] NAN_DEFAULT = 32'hFFC00000;
  localparam logic [31:0] NAN_QUIET   = 32'h00400000;
  localparam logic [31:0] GRAV        = 32'h3C20BA1F;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  zff_in_t     sample = '0;
  logic        zmp_valid;
  logic        zmp_stall = 1'b0;
  zff_out_t    zmp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic [63:0] cfg_regs [NUM_REGS];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;

  zmp_from_foot_force_sensors_unit u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------- binary32 arithmetic via exact binary64 ----------------
  function automatic logic f_nan(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic logic f_inf(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic logic f_zero(logic [31:0] a);
    return a[30:0] == 0;
  endfunction

  function automatic real f_to_real(logic [31:0] a);
    logic [22:0] m;
    int          p;
    m = a[22:0];
    if (a[30:0] == 0) return $bitstoreal({a[31], 63'd0});
    if (a[30:23] == 0) begin
      p = 0;
      for (int i = 0; i < 23; i++) if (m[i]) p = i;
      return $bitstoreal({a[31], 11'(p + 874), 52'({m, 29'd0} << (23 - p))});
    end
    return $bitstoreal({a[31], 11'({3'd0, a[30:23]} + 11'd896), m, 29'd0});
  endfunction

  function automatic logic [31:0] real_to_f(real v);
    logic [63:0] d, sig, mant;
    logic        s, g, st, rnd;
    logic [30:0] body;
    int          ue, sh;
    d = $realtobits(v);
    s = d[63];
    if (d[62:0] == 0) return {s, 31'd0};
    ue = int'(d[62:52]) - 1023;
    if (ue > 127) return {s, 8'hFF, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
    if (sh > 60) sh = 60;
    mant = sig >> sh;
    g = sig[sh-1];
    st = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
    rnd = g & (st | mant[0]);
    if (ue >= -126) body = {8'(ue + 127), mant[22:0]};
    else body = mant[30:0];
    body = body + 31'(rnd);
    return {s, body};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (f_nan(a)) return a | NAN_QUIET;
    if (f_nan(b)) return b | NAN_QUIET;
    if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) return NAN_DEFAULT;
    if (f_inf(a) || f_inf(b)) return {s, 8'hFF, 23'd0};
    if (f_zero(a) || f_zero(b)) return {s, 31'd0};
    return real_to_f(f_to_real(a) * f_to_real(b));
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    if (f_nan(a)) return a | NAN_QUIET;
    if (f_nan(b)) return b | NAN_QUIET;
    if (f_inf(a) && f_inf(b) && a[31] != b[31]) return NAN_DEFAULT;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    return real_to_f(f_to_real(a) + f_to_real(b));
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    if (f_nan(a)) return a | NAN_QUIET;
    if (f_nan(b)) return b | NAN_QUIET;
    return f_add(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (f_nan(a)) return a | NAN_QUIET;
    if (f_nan(b)) return b | NAN_QUIET;
    if ((f_inf(a) && f_inf(b)) || (f_zero(a) && f_zero(b))) return NAN_DEFAULT;
    if (f_inf(a) || f_zero(b)) return {s, 8'hFF, 23'd0};
    if (f_inf(b) || f_zero(a)) return {s, 31'd0};
    return real_to_f(f_to_real(a) / f_to_real(b));
  endfunction

  function automatic logic [31:0] half_decode(logic [15:0] h);
    logic [9:0] m;
    int         p;
    m = h[9:0];
    if (h[14:10] == 5'd31) return {h[15], 8'hFF, m, 13'd0};
    if (h[14:10] == 0) begin
      if (m == 0) return {h[15], 31'd0};
      p = 0;
      for (int i = 0; i < 10; i++) if (m[i]) p = i;
      return {h[15], 8'(p + 103), 23'({m, 13'd0} << (10 - p))};
    end
    return {h[15], 8'(h[14:10] + 112), m, 13'd0};
  endfunction

  function automatic logic [31:0] count_to_f(logic [SAMPLE_BITS-1:0] v);
    int p;
    if (v == 0) return 32'd0;
    p = 0;
    for (int i = 0; i < SAMPLE_BITS; i++) if (v[i]) p = i;
    return {1'b0, 8'(p + 127), 23'({23'd0, v} << (23 - p))};
  endfunction

  function automatic logic [31:0] load_curve(logic [31:0] v);
    logic [31:0] c3, c2, c1, t3, t2, t1;
    c3 = half_decode(cfg_regs[REG_LOAD_POLY][47:32]);
    c2 = half_decode(cfg_regs[REG_LOAD_POLY][31:16]);
    c1 = half_decode(cfg_regs[REG_LOAD_POLY][15:0]);
    t3 = f_mul(f_mul(f_mul(c3, v), v), v);
    t2 = f_mul(f_mul(c2, v), v);
    t1 = f_mul(c1, v);
    return f_add(f_add(t3, t2), t1);
  endfunction

  function automatic zff_out_t predict_zmp(zff_in_t w);
    zff_out_t    o;
    logic [31:0] q [4];
    logic [31:0] cnt [4];
    logic [31:0] f, p, r, reaction, t;
    logic [63:0] geo;
    cnt[0] = count_to_f(w.force_right_front);
    cnt[1] = count_to_f(w.force_left_front);
    cnt[2] = count_to_f(w.force_right_back);
    cnt[3] = count_to_f(w.force_left_back);
    r = 32'd0;
    for (int i = 0; i < 4; i++) begin
      f = cnt[i];
      p = f_add(f_mul(f_mul(half_decode(cfg_regs[i][47:32]), f), f),
                f_mul(half_decode(cfg_regs[i][31:16]), f));
      p = f_add(p, half_decode(cfg_regs[i][15:0]));
      r = f_add(r, p);
      q[i] = load_curve(p);
    end
    reaction = f_mul(load_curve(r), GRAV);
    geo = cfg_regs[REG_GEOMETRY];
    o.reaction_force = reaction;
    o.zero_reaction = f_zero(reaction);
    if (o.zero_reaction) begin
      o.zmp_x = 32'd0;
      o.zmp_y = 32'd0;
    end else begin
      t = f_mul(f_mul(f_add(q[0], q[2]), half_decode(geo[63:48])), GRAV);
      o.zmp_x = f_sub(f_div(t, reaction), half_decode(geo[31:16]));
      t = f_mul(f_mul(f_add(q[0], q[1]), half_decode(geo[47:32])), GRAV);
      o.zmp_y = f_sub(f_div(t, reaction), half_decode(geo[15:0]));
    end
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  class zmp_scoreboard;
    zff_out_t expected_q[$];

    function void note_frame(zff_in_t w);
      expected_q.insert(expected_q.size(), predict_zmp(w));
    endfunction

    task check_result(zff_out_t got);
      zff_out_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (got.zmp_x !== e.zmp_x)
        report_mismatch($sformatf("zmp_x %h exp %h", got.zmp_x, e.zmp_x));
      if (got.zmp_y !== e.zmp_y)
        report_mismatch($sformatf("zmp_y %h exp %h", got.zmp_y, e.zmp_y));
      if (got.reaction_force !== e.reaction_force)
        report_mismatch($sformatf("reaction_force %h exp %h",
                                  got.reaction_force, e.reaction_force));
      if (got.zero_reaction !== e.zero_reaction)
        report_mismatch($sformatf("zero_reaction %b exp %b",
                                  got.zero_reaction, e.zero_reaction));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  zmp_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) sb.note_frame(sample);
      if (zmp_valid && !zmp_stall) sb.check_result(zmp);
    end
  end

  // receiver: random stall, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (300) begin
          zmp_stall <= 1'b1;
          @(posedge clk);
        end
      end
      zmp_stall <= !quiet && ($urandom_range(0, 99) < 11);
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_regs[idx] = (idx == REG_GEOMETRY) ? val : {16'd0, val[47:0]};
    @(posedge clk);
  endtask

  task automatic send_frame(zff_in_t w);
    logic stalled;
    while (!quiet && $urandom_range(0, 99) < 11) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample <= w;
    sample_valid <= 1'b1;
    do begin
      @(negedge clk);
      stalled = sample_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_half(int kind);
    case (kind)
      1: return 16'($urandom);
      2: return {1'($urandom), 15'h7BFF};
      3: return {1'($urandom), 5'd0, 10'($urandom_range(1, 1023))};
      4: return 16'hFFFF;
      5: return {1'($urandom), 5'd31, 10'd0};
      default: return {1'($urandom), 5'($urandom_range(10, 18)), 10'($urandom)};
    endcase
  endfunction

  task automatic program_cfg(int kind, bit dead_load);
    logic [47:0] v;
    for (int i = 0; i < 5; i++) begin
      v = {pick_half(kind), pick_half(kind), pick_half(kind)};
      if (i == REG_LOAD_POLY && dead_load) v = '0;
      write_reg(3'(i), {16'($urandom), v});
    end
    write_reg(REG_GEOMETRY, {pick_half(kind), pick_half(kind), pick_half(kind),
                             pick_half(kind)});
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    zff_in_t w;
    logic [SAMPLE_BITS-1:0] d_vals [6];
    int kinds [9];
    d_vals = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800};
    kinds = '{0, 0, 1, 2, 3, 4, 5, 0, 1};
    foreach (cfg_regs[i]) cfg_regs[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset: zero reaction
    for (int i = 0; i < 4; i++) begin
      w = {d_vals[i], d_vals[i+1], d_vals[i+2], d_vals[5-i]};
      send_frame(w);
    end
    drain();

    // fixed calibration, directed counts
    write_reg(REG_RF_POLY, 64'h0000_1400_3C00_4000);
    write_reg(REG_LF_POLY, 64'hFFFF_1800_3E00_3C00);
    write_reg(REG_RB_POLY, 64'h0000_1000_4000_0000);
    write_reg(REG_LB_POLY, 64'h0000_9400_4200_4400);
    write_reg(REG_LOAD_POLY, 64'h0000_0400_2000_3C00);
    write_reg(REG_GEOMETRY, 64'h4900_4500_3800_B400);
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 3; j++) begin
        w = {d_vals[i], d_vals[(i+j) % 6], d_vals[(i+2*j+1) % 6], d_vals[5-i]};
        send_frame(w);
      end
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      program_cfg(kinds[ph], ph == 7);
      quiet = (ph == 2);
      if (ph == 4) hold_go = 1'b1;
      repeat (ph == 4 || ph == 5 ? 120 : 230) begin
        w = {pick_count(), pick_count(), pick_count(), pick_count()};
        send_frame(w);
      end
      drain();
      quiet = 1'b0;
    end

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
